### hdl/assert_macros.svh
// Assertion macros for the RTL of the block cipher.
// Depends on nothing; included by the top level, which carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ASSERT_AT(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### hdl/mmbc_pkg.sv
// Types, constants and bit packing functions of the modular multiply block cipher.
// Depends on nothing; imported by the top level and the testbench.
package mmbc_pkg;

   typedef enum logic {
      CMD_ENC = 1'b0,
      CMD_DEC = 1'b1
   } cmd_type;

   localparam logic [2:0] REG_MOD_01 = 3'd0;
   localparam logic [2:0] REG_MOD_23 = 3'd1;
   localparam logic [2:0] REG_ENC_01 = 3'd2;
   localparam logic [2:0] REG_ENC_23 = 3'd3;
   localparam logic [2:0] REG_DEC_01 = 3'd4;
   localparam logic [2:0] REG_DEC_23 = 3'd5;
   localparam logic [2:0] REG_XOR_01 = 3'd6;
   localparam logic [2:0] REG_XOR_23 = 3'd7;
   localparam int REG_COUNT = 8;

   localparam logic [7:0] CHECK_SEED = 8'hF8;
   localparam logic [7:0] LEN_MASK = 8'h3D;
   localparam int WORD_BITS = 18;

   localparam int DIV_BITS = 2;
   localparam int DIV_STAGES = 32 / DIV_BITS;
   localparam int UNIT_STAGES = 1 + DIV_STAGES;
   localparam int NSTAGE = 4 * UNIT_STAGES;

   typedef struct packed {
      cmd_type cmd;
      logic [63:0] lo;
      logic [23:0] hi;
      logic [7:0] len;
      logic [3:0][31:0] w;
      logic [3:0][15:0] pt;
   } item_type;

   function automatic int word_bit(input int j);
      if (j < 8) return 7 - j;
      else if (j < 16) return 23 - j;
      else return 33 - j;
   endfunction

   function automatic logic [71:0] pack_words(input logic [3:0][31:0] w);
      logic [71:0] res;
      int s;
      res = '0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < WORD_BITS; j++) begin
            s = WORD_BITS * i + j;
            res[8 * (s / 8) + 7 - (s % 8)] = w[i][word_bit(j)];
         end
      end
      return res;
   endfunction

   function automatic logic [3:0][31:0] unpack_words(input logic [87:0] blk);
      logic [3:0][31:0] res;
      int s;
      res = '0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < WORD_BITS; j++) begin
            s = WORD_BITS * i + j;
            res[i][word_bit(j)] = blk[8 * (s / 8) + 7 - (s % 8)];
         end
      end
      return res;
   endfunction

endpackage

### hdl/modmul_block_cipher.sv
// Top level of the modular multiply block cipher: register file and full pipeline.
// Depends on mmbc_pkg and assert_macros.svh.
//
// Requests arrive on the req_ channel: tdata carries data_lo, data_hi and length,
// tuser carries the command (0 encrypt, 1 decrypt). Each request gives exactly one
// response on the rsp_ channel with out_lo, out_hi, length_out and check_ok.
// Eight 64-bit key and modulus registers are written through the csr_ channel,
// which is always ready; writes to an index of 8 or more are dropped. Registers
// should only be written while no request is in flight.
// The pipeline holds one input stage, four multiply and remainder units of
// seventeen stages each (one multiply stage, then sixteen restoring remainder
// stages at two bits per stage), and the output register. A new request is taken
// every cycle while the pipeline is not stalled. The remainder chain sets the depth;
// the four units sit in series because each encrypted word depends on the
// previous one.
// When the receiver stalls with a response waiting, the whole pipeline holds and
// req_tready drops; nothing is lost or repeated. Reset clears the eight registers to
// zero and empties the pipeline.
`include "assert_macros.svh"

module modmul_block_cipher
   import mmbc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // data_lo [63:0], data_hi [87:64], length [95:88]
   input  logic [95:0]  req_tdata,
   // cmd [0]
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_lo [63:0], out_hi [87:64], length_out [95:88], check_ok [96], zero [103:97]
   output logic [103:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_index,
   input  logic [63:0]  csr_data
);

   logic [REG_COUNT-1:0][63:0] cfg_ff;
   logic adv;
   logic in_valid_ff;
   item_type in_ff, in_in;
   logic [NSTAGE-1:0] valid_ff;
   item_type item_ff [NSTAGE];
   logic [31:0] p_ff [NSTAGE];
   logic [31:0] rem_ff [NSTAGE];
   item_type item_in [NSTAGE];
   logic [31:0] p_in [NSTAGE];
   logic [31:0] rem_in [NSTAGE];
   logic rsp_tvalid_ff;
   logic [103:0] rsp_tdata_ff, rsp_tdata_in;
   logic [3:0][31:0] xk;

   assign csr_ready = 1'b1;
   assign adv = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

   always_comb begin
      for (int u = 0; u < 4; u++) begin
         xk[u] = cfg_ff[REG_XOR_01 + 3'(u / 2)][32 * (u % 2) +: 32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_index < 8'(REG_COUNT)) begin
         cfg_ff[csr_index[2:0]] <= csr_data;
      end
   end

   always_comb begin
      logic [3:0][31:0] wv;
      wv = unpack_words({req_tdata[87:64], req_tdata[63:0]});
      wv[2] = wv[2] ^ xk[2] ^ {16'h0, wv[3][15:0]};
      wv[1] = wv[1] ^ xk[1] ^ {16'h0, wv[2][15:0]};
      wv[0] = wv[0] ^ xk[0] ^ {16'h0, wv[1][15:0]};
      in_in.cmd = cmd_type'(req_tuser);
      in_in.lo = req_tdata[63:0];
      in_in.hi = req_tdata[87:64];
      in_in.len = req_tdata[95:88];
      in_in.w = (req_tuser == CMD_DEC) ? wv : '0;
      in_in.pt = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff <= in_in;
      end
   end

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      localparam int U = s / UNIT_STAGES;
      localparam int POS = s % UNIT_STAGES;
      logic src_valid;

      if (s == 0) begin : g_first
         assign src_valid = in_valid_ff;
      end else begin : g_next
         assign src_valid = valid_ff[s-1];
      end

      if (POS == 0) begin : g_mul
         logic [31:0] ek;
         logic [31:0] dk;

         assign ek = cfg_ff[REG_ENC_01 + 3'(U / 2)][32 * (U % 2) +: 32];
         assign dk = cfg_ff[REG_DEC_01 + 3'(U / 2)][32 * (U % 2) +: 32];

         always_comb begin
            item_type src;
            logic [15:0] chain;
            logic [31:0] a;
            logic [31:0] prod;
            if (s == 0) src = in_ff;
            else src = item_ff[(s == 0) ? 0 : s - 1];
            chain = (U == 0) ? 16'h0 : src.w[(U == 0) ? 0 : U - 1][15:0];
            if (src.cmd == CMD_DEC) begin
               a = src.w[U];
               prod = a * dk;
            end else begin
               a = xk[U] ^ {16'h0, src.lo[16 * U +: 16]} ^ {16'h0, chain};
               prod = a * ek;
            end
            item_in[s] = src;
            p_in[s] = prod;
            rem_in[s] = '0;
         end
      end else begin : g_div
         localparam int B_TOP = 31 - DIV_BITS * (POS - 1);
         logic [31:0] mk;

         assign mk = cfg_ff[REG_MOD_01 + 3'(U / 2)][32 * (U % 2) +: 32];

         always_comb begin
            item_type src;
            logic [31:0] r;
            logic [32:0] t;
            logic [4:0] bi;
            logic [31:0] res;
            logic [15:0] chain;
            src = item_ff[s-1];
            r = rem_ff[s-1];
            for (int k = 0; k < DIV_BITS; k++) begin
               bi = 5'(B_TOP - k);
               t = {r, p_ff[s-1][bi]};
               if (t >= {1'b0, mk}) t = t - {1'b0, mk};
               r = t[31:0];
            end
            res = (mk == 32'h0) ? p_ff[s-1] : r;
            chain = (U == 0) ? 16'h0 : src.w[(U == 0) ? 0 : U - 1][15:0];
            item_in[s] = src;
            if (POS == DIV_STAGES) begin
               if (src.cmd == CMD_DEC) begin
                  item_in[s].pt[U] = res[15:0] ^ xk[U][15:0] ^ chain;
               end else begin
                  item_in[s].w[U] = res;
               end
            end
            p_in[s] = p_ff[s-1];
            rem_in[s] = r;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (adv) begin
            valid_ff[s] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            item_ff[s] <= item_in[s];
            p_ff[s] <= p_in[s];
            rem_ff[s] <= rem_in[s];
         end
      end
   end

   always_comb begin
      item_type fin;
      logic [3:0][31:0] wf;
      logic [71:0] bits;
      logic [63:0] plain;
      logic [7:0] cs;
      logic [7:0] rlen;
      fin = item_ff[NSTAGE-1];
      wf = '0;
      bits = '0;
      plain = '0;
      rlen = '0;
      rsp_tdata_in = '0;
      cs = CHECK_SEED;
      if (fin.cmd == CMD_DEC) begin
         plain = fin.pt;
         for (int i = 0; i < 8; i++) cs = cs ^ plain[8 * i +: 8];
         rlen = fin.hi[23:16] ^ fin.hi[15:8] ^ LEN_MASK;
         rsp_tdata_in[63:0] = plain;
         rsp_tdata_in[95:88] = rlen;
         rsp_tdata_in[96] = (cs == fin.hi[23:16]);
      end else begin
         for (int i = 0; i < 8; i++) cs = cs ^ fin.lo[8 * i +: 8];
         for (int i = 0; i < 3; i++) begin
            wf[i] = fin.w[i] ^ xk[i] ^ {16'h0, fin.w[i+1][15:0]};
         end
         wf[3] = fin.w[3];
         bits = pack_words(wf);
         rsp_tdata_in[63:0] = bits[63:0];
         rsp_tdata_in[87:64] = {cs, cs ^ fin.len ^ LEN_MASK, bits[71:64]};
         rsp_tdata_in[96] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= valid_ff[NSTAGE-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   `ASSERT_AT(a_accept_enters, clock, reset, req_tvalid && req_tready |=> in_valid_ff, "accepted request did not enter the pipeline")
   `ASSERT_AT(a_stall_holds, clock, reset, !adv |=> $stable(valid_ff) && $stable(in_valid_ff), "pipeline moved during a stall")
   `ASSERT_AT(a_last_to_out, clock, reset, adv && valid_ff[NSTAGE-1] |=> rsp_tvalid_ff, "finished request did not reach the output")
   `ASSERT_NEVER(a_dec_top_word, clock, reset, in_valid_ff && in_ff.cmd == CMD_DEC && in_ff.w[3][31:18] != 14'h0, "unpacked word has bits above bit 17")

endmodule

### tb/tb_top.sv
// Self-checking testbench of the modular multiply block cipher top level.
// Depends on mmbc_pkg and modmul_block_cipher; a scoreboard class predicts each response.

class cipher_scoreboard;
   logic [63:0] regs[8];
   logic [103:0] pending_rsp[$];
   int errors;

   function new();
      for (int i = 0; i < 8; i++) regs[i] = '0;
      errors = 0;
   endfunction

   function logic [31:0] key_word(logic [2:0] base, int w);
      logic [63:0] r;
      r = regs[base + 3'(w / 2)];
      return (w % 2) ? r[63:32] : r[31:0];
   endfunction

   function logic [31:0] mod_mul(logic [31:0] a, logic [31:0] k, logic [31:0] m);
      logic [31:0] p;
      p = a * k;
      return (m == 0) ? p : p % m;
   endfunction

   function void write_reg(logic [7:0] idx, logic [63:0] val);
      if (idx < mmbc_pkg::REG_COUNT) regs[idx[2:0]] = val;
   endfunction

   function logic [103:0] cipher_result(mmbc_pkg::cmd_type cmd, logic [63:0] lo,
                                         logic [23:0] hi, logic [7:0] len);
      logic [31:0] w[4];
      logic [7:0] blk[11];
      logic [31:0] chain, t;
      logic [7:0] cs;
      logic [63:0] plain;
      int s, p;
      chain = 0;
      cs = mmbc_pkg::CHECK_SEED;
      if (cmd == mmbc_pkg::CMD_ENC) begin
         for (int i = 0; i < 8; i++) cs ^= lo[8 * i +: 8];
         for (int i = 0; i < 4; i++) begin
            w[i] = mod_mul(key_word(mmbc_pkg::REG_XOR_01, i) ^ {16'h0, lo[16 * i +: 16]} ^ chain,
                           key_word(mmbc_pkg::REG_ENC_01, i), key_word(mmbc_pkg::REG_MOD_01, i));
            chain = {16'h0, w[i][15:0]};
         end
         for (int i = 0; i < 3; i++)
            w[i] = w[i] ^ key_word(mmbc_pkg::REG_XOR_01, i) ^ {16'h0, w[i + 1][15:0]};
         for (int i = 0; i < 11; i++) blk[i] = 0;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 18; j++) begin
               s = (j < 8) ? 7 - j : (j < 16) ? 23 - j : 33 - j;
               p = 18 * i + j;
               blk[p / 8][7 - p % 8] = w[i][s];
            end
         end
         blk[9] = cs ^ len ^ mmbc_pkg::LEN_MASK;
         blk[10] = cs;
         return {7'h0, 1'b1, 8'h00, blk[10], blk[9], blk[8], blk[7], blk[6], blk[5],
                 blk[4], blk[3], blk[2], blk[1], blk[0]};
      end
      for (int i = 0; i < 8; i++) blk[i] = lo[8 * i +: 8];
      blk[8] = hi[7:0];
      blk[9] = hi[15:8];
      blk[10] = hi[23:16];
      for (int i = 0; i < 4; i++) begin
         w[i] = 0;
         for (int j = 0; j < 18; j++) begin
            s = (j < 8) ? 7 - j : (j < 16) ? 23 - j : 33 - j;
            p = 18 * i + j;
            w[i][s] = blk[p / 8][7 - p % 8];
         end
      end
      for (int i = 2; i >= 0; i--)
         w[i] = w[i] ^ key_word(mmbc_pkg::REG_XOR_01, i) ^ {16'h0, w[i + 1][15:0]};
      plain = 0;
      for (int i = 0; i < 4; i++) begin
         t = mod_mul(w[i], key_word(mmbc_pkg::REG_DEC_01, i), key_word(mmbc_pkg::REG_MOD_01, i))
             ^ key_word(mmbc_pkg::REG_XOR_01, i) ^ chain;
         chain = {16'h0, w[i][15:0]};
         plain[16 * i +: 16] = t[15:0];
      end
      for (int i = 0; i < 8; i++) cs ^= plain[8 * i +: 8];
      return {7'h0, cs == blk[10], blk[10] ^ blk[9] ^ mmbc_pkg::LEN_MASK, 24'h0, plain};
   endfunction

   function void note_request(logic cmd, logic [95:0] data);
      pending_rsp.push_back(cipher_result(mmbc_pkg::cmd_type'(cmd), data[63:0],
                                          data[87:64], data[95:88]));
   endfunction

   function void check_response(logic [103:0] got);
      logic [103:0] want;
      if (pending_rsp.size() == 0) begin
         $error("response with no request pending: %h", got);
         errors++;
         return;
      end
      want = pending_rsp.pop_front();
      if (got[63:0] !== want[63:0]) begin
         $error("out_lo expected %h actual %h", want[63:0], got[63:0]);
         errors++;
      end
      if (got[87:64] !== want[87:64]) begin
         $error("out_hi expected %h actual %h", want[87:64], got[87:64]);
         errors++;
      end
      if (got[95:88] !== want[95:88]) begin
         $error("length_out expected %h actual %h", want[95:88], got[95:88]);
         errors++;
      end
      if (got[96] !== want[96]) begin
         $error("check_ok expected %b actual %b", want[96], got[96]);
         errors++;
      end
      if (got[103:97] !== want[103:97]) begin
         $error("pad expected %h actual %h", want[103:97], got[103:97]);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import mmbc_pkg::*;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [95:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [103:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [7:0] csr_index;
   logic [63:0] csr_data;
   int send_idle, recv_idle, quiet_cycles;
   cipher_scoreboard sb;

   modmul_block_cipher i_dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_valid)
            quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles > 5000) begin
            $display("tb_top failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic write_csr(logic [7:0] idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      while (sb.pending_rsp.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic send_block(logic cmd, logic [63:0] lo, logic [23:0] hi, logic [7:0] len);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= cmd;
      req_tdata <= {len, hi, lo};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] edge_word();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         2: return {32'h0, $urandom};
         default: return rand64();
      endcase
   endfunction

   task automatic load_keys(int kind);
      for (int r = 0; r < REG_COUNT; r++)
         write_csr(r[7:0], kind == 0 ? 64'h0 : kind == 1 ? '1 :
                   (r < 2 && $urandom_range(3) == 0) ?
                   {16'h0, 16'($urandom_range(65535)), 16'h0, 16'($urandom_range(65535))} :
                   edge_word());
   endtask

   task automatic enc_dec_pair();
      logic [63:0] pt;
      logic [103:0] ct;
      logic [7:0] len;
      pt = rand64();
      len = 8'($urandom_range(255));
      ct = sb.cipher_result(CMD_ENC, pt, 24'h0, len);
      send_block(CMD_ENC, pt, 24'($urandom_range(24'hFFFFFF)), len);
      if ($urandom_range(4) == 0) ct[$urandom_range(87)] ^= 1'b1;
      send_block(CMD_DEC, ct[63:0], ct[87:64], 8'($urandom_range(255)));
   endtask

   initial begin
      sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tuser = 0;
      req_tdata = '0;
      rsp_tready = 0;
      csr_valid = 0;
      csr_index = '0;
      csr_data = '0;
      send_idle = 0;
      recv_idle = 0;
      quiet_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed requests with all registers zero, then all ones.
      send_block(CMD_ENC, '0, '0, '0);
      send_block(CMD_ENC, '1, '1, 8'hFF);
      send_block(CMD_DEC, '0, '0, '0);
      send_block(CMD_DEC, '1, '1, 8'hFF);
      req_tvalid <= 0;
      drain();
      load_keys(1);
      write_csr(8'd8, '1);
      write_csr(8'hFF, '0);
      send_block(CMD_ENC, '0, '0, 8'h00);
      send_block(CMD_ENC, '1, '0, 8'hFF);
      send_block(CMD_DEC, '1, '1, 8'h5A);
      send_block(CMD_DEC, 64'h0123456789ABCDEF, 24'hA5C3F0, 8'h00);
      req_tvalid <= 0;
      drain();
      write_csr(8'(REG_MOD_01), 64'h00000007_00010001);
      write_csr(8'(REG_MOD_23), 64'h0);
      write_csr(8'(REG_ENC_01), 64'h00000003_0000FFFF);
      write_csr(8'(REG_DEC_01), 64'h00000005_00000002);
      for (int i = 0; i < 6; i++) enc_dec_pair();
      req_tvalid <= 0;
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         send_idle = (ph < 2) ? 23 : (ph < 4) ? 82 : 0;
         recv_idle = (ph < 2) ? 82 : (ph < 4) ? 23 : 0;
         load_keys(ph == 5 ? 1 : 2);
         for (int n = 0; n < 36; n++) begin
            if ($urandom_range(3) == 0)
               send_block(1'($urandom_range(1)), rand64(), 24'($urandom_range(24'hFFFFFF)),
                          8'($urandom_range(255)));
            else enc_dec_pair();
            if (n == 16) begin
               req_tvalid <= 0;
               while (sb.pending_rsp.size() != 0) @(negedge clock);
            end
         end
         req_tvalid <= 0;
         drain();
      end
      recv_idle = 0;
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end
endmodule

### files.f
+incdir+hdl
hdl/mmbc_pkg.sv
hdl/modmul_block_cipher.sv
tb/tb_top.sv
